@@ sv/swm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swm_pkg
// shared constants and types of the sliding window median core
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int unsigned DEF_MAX_WINDOW   = 64;
  localparam int unsigned DEF_SAMPLE_WIDTH = 16;

  localparam int unsigned CFG_W      = 7;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned REG_IDX_W  = APB_ADDR_W - 2;

  localparam logic [CFG_W-1:0]     WINDOW_SIZE_RST = 7'd3;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_SIZE = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_UPD  = 3'b010,
    ST_MED  = 3'b100
  } swm_state_e;

  typedef struct packed {
    logic up;
    logic down;
  } swm_move_t;

endpackage
`default_nettype wire

@@ sv/swm_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swm_cell
// one slot of the sorted window: holds a value and its age, decides locally
// whether it moves up, down or stays when the oldest value leaves and a new
// sample is inserted, and takes over a neighbor's entry when that one moves in
// ----------------------------------------------------------------------------
module swm_cell #(
  parameter int unsigned SAMPLE_WIDTH = swm_pkg::DEF_SAMPLE_WIDTH,
  parameter int unsigned AGE_W        = 6,
  parameter int unsigned CNT_W        = 7,
  parameter int unsigned IDX          = 0
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           en_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] rm_val_i,
  input  wire                           drop_i,
  input  wire logic [AGE_W-1:0]         drop_age_i,
  input  wire logic [CNT_W-1:0]         fill_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] left_val_i,
  input  wire logic [AGE_W-1:0]         left_age_i,
  input  wire swm_pkg::swm_move_t       left_mv_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] right_val_i,
  input  wire logic [AGE_W-1:0]         right_age_i,
  input  wire swm_pkg::swm_move_t       right_mv_i,
  output logic signed [SAMPLE_WIDTH-1:0] val_o,
  output logic [AGE_W-1:0]              age_o,
  output swm_pkg::swm_move_t            mv_o
);
  import swm_pkg::*;

  logic signed [SAMPLE_WIDTH-1:0] val_q, val_d;
  logic [AGE_W-1:0]               age_q, age_d;
  logic valid, rm, above, gt, keep, stay;

  assign valid = (CNT_W'(IDX) < fill_i);
  assign rm    = valid && drop_i && (age_q == drop_age_i);
  // strictly above the leaving entry in (value, newer-on-top) order
  assign above = valid && drop_i &&
                 ((val_q > rm_val_i) || ((val_q == rm_val_i) && (age_q < drop_age_i)));
  assign gt    = valid && (val_q > sample_i);
  assign keep  = valid && !rm;
  assign stay  = keep && (above == gt);

  assign mv_o.up   = keep && gt && !above;
  assign mv_o.down = keep && above && !gt;

  always_comb begin
    if (right_mv_i.down) begin
      val_d = right_val_i;
      age_d = right_age_i + AGE_W'(1);
    end else if (left_mv_i.up) begin
      val_d = left_val_i;
      age_d = left_age_i + AGE_W'(1);
    end else if (stay) begin
      val_d = val_q;
      age_d = age_q + AGE_W'(1);
    end else begin
      val_d = sample_i;
      age_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
      age_q <= '0;
    end else if (en_i) begin
      val_q <= val_d;
      age_q <= age_d;
    end
  end

  assign val_o = val_q;
  assign age_o = age_q;

endmodule
`default_nettype wire

@@ sv/sliding_window_median_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_median_core
// running median over the most recent window_size samples
// ----------------------------------------------------------------------------
// An item that completes a full window passes through ST_IDLE, ST_UPD and
// ST_MED, and an item that only fills the window through ST_IDLE and ST_UPD.
// In ST_IDLE the sample is taken and the sample leaving the window is read
// from the arrival-order delay memory. In ST_UPD every cell of the sorted
// chain drops the leaving entry and inserts the new one in a single step.
// In ST_MED the two middle cells are selected and their sum is loaded into
// the output register. ST_MED is held while the previous result is still
// waiting for the receiver. The next item is taken once the output register
// is loaded, or right after ST_UPD while the window is filling. No result comes out until
// the window has filled; writing window_size restarts the fill. A
// window_size of zero acts as one, a value above the maximum as the maximum.
// ----------------------------------------------------------------------------
module sliding_window_median_core #(
  parameter int unsigned MAX_WINDOW   = swm_pkg::DEF_MAX_WINDOW,
  parameter int unsigned SAMPLE_WIDTH = swm_pkg::DEF_SAMPLE_WIDTH
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_i,
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output logic signed [SAMPLE_WIDTH:0]       median_sum_o,
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire logic [swm_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [swm_pkg::APB_DATA_W-1:0] pwdata,
  output logic [swm_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);
  import swm_pkg::*;

  localparam int unsigned SW    = SAMPLE_WIDTH;
  localparam int unsigned AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned PW    = CNT_W + 1;

  swm_state_e st_q, st_d;

  logic [CFG_W-1:0]        ws_q;
  logic [CNT_W-1:0]        eff;
  logic [AW-1:0]           lo_idx, hi_idx;
  logic [CNT_W-1:0]        fill_q;
  logic [AW-1:0]           wp_q;
  logic                    drop_q;
  logic signed [SW-1:0]    sample_q;
  logic signed [SW-1:0]    rd_q;
  logic signed [SW-1:0]    mem_q [MAX_WINDOW];
  logic [PW-1:0]           old_sum, old_wrap;
  logic [AW-1:0]           old_addr;
  logic                    in_acc, cfg_wr, upd, load_out;
  logic                    out_valid_q;
  logic signed [SW:0]      out_q;
  logic signed [SW:0]      med_sum;

  logic signed [SW-1:0] cell_val [MAX_WINDOW];
  logic [AW-1:0]        cell_age [MAX_WINDOW];
  swm_move_t            cell_mv  [MAX_WINDOW];

  // effective window and middle indexes
  always_comb begin
    if (ws_q == '0) begin
      eff = CNT_W'(1);
    end else if (32'(ws_q) > MAX_WINDOW) begin
      eff = CNT_W'(MAX_WINDOW);
    end else begin
      eff = CNT_W'(ws_q);
    end
  end

  assign lo_idx = AW'((eff - CNT_W'(1)) >> 1);
  assign hi_idx = AW'(eff >> 1);

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[APB_ADDR_W-1:2] == REG_WINDOW_SIZE);
  assign prdata = (paddr[APB_ADDR_W-1:2] == REG_WINDOW_SIZE) ?
                  APB_DATA_W'(ws_q) : '0;

  // handshakes
  assign in_ready_o  = (st_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign upd         = (st_q == ST_UPD);
  assign load_out    = (st_q == ST_MED) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign median_sum_o = out_q;

  // address of the sample that leaves the window
  assign old_sum  = PW'(wp_q) + PW'(MAX_WINDOW) - PW'(eff);
  assign old_wrap = (old_sum >= PW'(MAX_WINDOW)) ? (old_sum - PW'(MAX_WINDOW)) : old_sum;
  assign old_addr = AW'(old_wrap);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q     <= mem_q[old_addr];
      sample_q <= sample_i;
    end
    if (upd) begin
      mem_q[wp_q] <= sample_q;
    end
  end

  // sorted chain
  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    logic signed [SW-1:0] lv, rv;
    logic [AW-1:0]        la, ra;
    swm_move_t            lm, rm;

    if (k > 0) begin : g_left
      assign lv = cell_val[k-1];
      assign la = cell_age[k-1];
      assign lm = cell_mv[k-1];
    end else begin : g_left_edge
      assign lv = '0;
      assign la = '0;
      assign lm = '0;
    end

    if (k < MAX_WINDOW - 1) begin : g_right
      assign rv = cell_val[k+1];
      assign ra = cell_age[k+1];
      assign rm = cell_mv[k+1];
    end else begin : g_right_edge
      assign rv = '0;
      assign ra = '0;
      assign rm = '0;
    end

    swm_cell #(
      .SAMPLE_WIDTH (SW),
      .AGE_W        (AW),
      .CNT_W        (CNT_W),
      .IDX          (k)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (upd),
      .sample_i    (sample_q),
      .rm_val_i    (rd_q),
      .drop_i      (drop_q),
      .drop_age_i  (AW'(eff - CNT_W'(1))),
      .fill_i      (fill_q),
      .left_val_i  (lv),
      .left_age_i  (la),
      .left_mv_i   (lm),
      .right_val_i (rv),
      .right_age_i (ra),
      .right_mv_i  (rm),
      .val_o       (cell_val[k]),
      .age_o       (cell_age[k]),
      .mv_o        (cell_mv[k])
    );
  end

  assign med_sum = {cell_val[lo_idx][SW-1], cell_val[lo_idx]} +
                   {cell_val[hi_idx][SW-1], cell_val[hi_idx]};

  // sequencing
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (in_acc) st_d = ST_UPD;
      end
      ST_UPD: begin
        if (drop_q || ((fill_q + CNT_W'(1)) == eff)) st_d = ST_MED;
        else st_d = ST_IDLE;
      end
      ST_MED: begin
        if (load_out) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      ws_q        <= WINDOW_SIZE_RST;
      fill_q      <= '0;
      wp_q        <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_wr) begin
        ws_q   <= pwdata[CFG_W-1:0];
        fill_q <= '0;
      end else if (upd && !drop_q) begin
        fill_q <= fill_q + CNT_W'(1);
      end
      if (in_acc) begin
        drop_q <= (fill_q >= eff);
      end
      if (upd) begin
        wp_q <= (wp_q == AW'(MAX_WINDOW - 1)) ? '0 : wp_q + AW'(1);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= med_sum;
    end
  end

  // checks
  a_fill_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= eff)
    else $error("fill count beyond window");

  a_out_from_med: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(st_q == ST_MED))
    else $error("result raised outside median select");

  a_med_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_UPD) |=> ((st_q == ST_MED) == (fill_q == eff)))
    else $error("median select does not match full window");

  a_single_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd |-> !(cell_mv[0].down))
    else $error("bottom cell moved down");

endmodule
`default_nettype wire

@@ tb/tb_sliding_window_median_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_window_median_core
// self-checking bench for the running median core
// ----------------------------------------------------------------------------
// Drives signed samples through the valid/ready input channel and checks every
// median sum against an internal sorted-window predictor that tracks sample
// ages and the fill count. The window_size register is rewritten over the APB
// port between phases (zero, one, even and odd sizes, the maximum and values
// above it), and the sender and receiver idle at random in separate phases.
// ----------------------------------------------------------------------------

class median_scoreboard;
  localparam int unsigned MAX_WIN = swm_pkg::DEF_MAX_WINDOW;
  localparam int unsigned SW      = swm_pkg::DEF_SAMPLE_WIDTH;

  logic signed [SW-1:0]     sorted_q [MAX_WIN];
  logic [5:0]               age_q    [MAX_WIN];
  int unsigned              fill;
  logic [swm_pkg::CFG_W-1:0] window_reg;
  logic signed [SW:0]       median_q [$];
  int unsigned              error_count;

  function new();
    for (int i = 0; i < MAX_WIN; i++) begin
      sorted_q[i] = '0;
      age_q[i]    = '0;
    end
    fill        = 0;
    window_reg  = swm_pkg::WINDOW_SIZE_RST;
    error_count = 0;
  endfunction

  function void set_window(logic [swm_pkg::CFG_W-1:0] w);
    window_reg = w;
    fill       = 0;
  endfunction

  function int unsigned span();
    if (window_reg == 0) return 1;
    if (window_reg > MAX_WIN) return MAX_WIN;
    return window_reg;
  endfunction

  function void note_sample(logic signed [SW-1:0] s);
    int unsigned w;
    int unsigned pos;
    logic signed [SW:0] sum;
    w = span();
    // drop the oldest entry by age, keeping the order
    while (fill >= w) begin
      pos = 0;
      for (int unsigned i = 1; i < fill; i++)
        if (age_q[i] > age_q[pos]) pos = i;
      for (int unsigned i = pos; i + 1 < fill; i++) begin
        sorted_q[i] = sorted_q[i+1];
        age_q[i]    = age_q[i+1];
      end
      fill--;
    end
    for (int unsigned i = 0; i < fill; i++) age_q[i]++;
    // new sample goes after equal values
    pos = fill;
    while (pos > 0 && sorted_q[pos-1] > s) begin
      sorted_q[pos] = sorted_q[pos-1];
      age_q[pos]    = age_q[pos-1];
      pos--;
    end
    sorted_q[pos] = s;
    age_q[pos]    = '0;
    fill++;
    if (fill >= w) begin
      sum = sorted_q[(w-1)/2] + sorted_q[w/2];
      median_q.push_back(sum);
    end
  endfunction

  task report(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task check_median(logic signed [SW:0] got);
    logic signed [SW:0] want;
    if (median_q.size() == 0) begin
      report($sformatf("median_sum %0d with no item pending", got));
    end else begin
      want = median_q.pop_front();
      if (got !== want)
        report($sformatf("median_sum %0d, expected %0d", got, want));
    end
  endtask
endclass

module tb_sliding_window_median_core;
  import swm_pkg::*;

  localparam int unsigned SW = DEF_SAMPLE_WIDTH;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_ready_o;
  logic signed [SW-1:0]        sample_i    = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic signed [SW:0]          median_sum_o;
  logic                        psel        = 1'b0;
  logic                        penable     = 1'b0;
  logic                        pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0]       paddr       = '0;
  logic [APB_DATA_W-1:0]       pwdata      = '0;
  logic [APB_DATA_W-1:0]       prdata;
  logic                        pready;

  int unsigned       tx_idle_pct = 0;
  int unsigned       rx_stall_pct = 0;
  median_scoreboard  sb = new();

  localparam logic [CFG_W-1:0] WINDOW_PLAN [13] = '{
    7'd1, 7'd0, 7'd127, 7'd64, 7'd2, 7'd3, 7'd5, 7'd8, 7'd17, 7'd33, 7'd65, 7'd4, 7'd0
  };

  sliding_window_median_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_i     (sample_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .median_sum_o (median_sum_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    #1_000_000;
    $display("FAILURE");
    $finish;
  end

  // result side with random stalls
  initial begin
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_median(median_sum_o);
      out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic push_sample(input logic signed [SW-1:0] s);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(s);
  endtask

  // idle between phases: all results in, then room for an item with no result
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.median_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [CFG_W-1:0] w);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_WINDOW_SIZE, 2'b00};
    pwdata  <= APB_DATA_W'(w);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_window(w);
  endtask

  function automatic logic signed [SW-1:0] pick_sample();
    int unsigned kind;
    kind = $urandom_range(9);
    if (kind <= 5) return SW'($urandom);
    if (kind <= 7) return SW'($signed($urandom_range(6)) - 3);
    return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
  endfunction

  initial begin
    logic signed [SW-1:0] directed_w3 [16] = '{
      16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000,
      16'sh0000, 16'shffff, 16'sh0001, 16'sh0005, 16'sh0005, 16'sh0005,
      16'sh8000, 16'sh7fff, 16'sh0000, 16'sh7fff
    };
    logic signed [SW-1:0] directed_w2 [4] = '{16'sd100, -16'sd100, 16'sh7fff, 16'sh8000};
    logic signed [SW-1:0] directed_w1 [3] = '{16'sh8000, 16'sh7fff, 16'sh0000};
    logic [CFG_W-1:0]     w;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset window of three, then even and single windows
    foreach (directed_w3[i]) push_sample(directed_w3[i]);
    drain();
    write_window(7'd2);
    foreach (directed_w2[i]) push_sample(directed_w2[i]);
    drain();
    write_window(7'd1);
    foreach (directed_w1[i]) push_sample(directed_w1[i]);
    drain();

    for (int p = 0; p < 13; p++) begin
      case (p % 4)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct  = 74;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 74;
        end
        default: begin
          tx_idle_pct  = 27;
          rx_stall_pct = 27;
        end
      endcase
      w = (p == 12) ? CFG_W'($urandom_range(64, 1)) : WINDOW_PLAN[p];
      write_window(w);
      for (int n = 0; n < 102; n++) push_sample(pick_sample());
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (sb.error_count == 0 && sb.median_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
